// File: design/scc_pkg.sv
// Shared types and constants for the set-associative cache controller.
// No dependencies; every other design file but scc_queue imports this package.
`default_nettype none

package scc_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 4;
    localparam int OUT_COUNT_W = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACE_FIFO   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_BACK     = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAYS_IN_USE    = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SET_INDEX_BITS = 4'd3;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic       replace_fifo;
        logic       write_back;
        logic [3:0] ways_in_use;
        logic [3:0] set_index_bits;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        replace_fifo:   1'b0,
        write_back:     1'b1,
        ways_in_use:    4'd8,
        set_index_bits: 4'd8
    };

    typedef enum logic {
        BK_IDLE,
        BK_UPDATE
    } back_state_t;

endpackage

`default_nettype wire

// File: design/scc_if.sv
// Channel interfaces of the cache controller: request, response and configuration.
// Depends on scc_pkg.
`default_nettype none

interface scc_req_if #(
    parameter int ADDR_BITS = 48
);
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [ADDR_BITS-1:0] byte_address;

    modport source (output valid, output func, output byte_address, input ready);
    modport sink   (input valid, input func, input byte_address, output ready);
endinterface

interface scc_rsp_if import scc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic                   mem_fetch;
    logic                   mem_store;
    logic                   evicted;
    logic [OUT_COUNT_W-1:0] total_hits;
    logic [OUT_COUNT_W-1:0] total_read_misses;
    logic [OUT_COUNT_W-1:0] total_write_misses;
    logic [OUT_COUNT_W-1:0] total_mem_reads;
    logic [OUT_COUNT_W-1:0] total_mem_writes;

    modport source (
        output valid, output hit, output mem_fetch, output mem_store, output evicted,
        output total_hits, output total_read_misses, output total_write_misses,
        output total_mem_reads, output total_mem_writes, input ready
    );
    modport sink (
        input valid, input hit, input mem_fetch, input mem_store, input evicted,
        input total_hits, input total_read_misses, input total_write_misses,
        input total_mem_reads, input total_mem_writes, output ready
    );
endinterface

interface scc_cfg_if import scc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/scc_front.sv
// Front end: holds the configuration registers, accepts requests and splits
// the address into tag and set index. Depends on scc_pkg and scc_if.
`default_nettype none

module scc_front import scc_pkg::*; #(
    parameter int ADDR_BITS   = 48,
    parameter int BLOCK_BYTES = 64,
    parameter int MAX_SETS    = 256,
    localparam int OFF_BITS   = $clog2(BLOCK_BYTES),
    localparam int TAG_W      = ADDR_BITS - OFF_BITS,
    localparam int SET_LOG    = $clog2(MAX_SETS),
    localparam int SET_W      = (SET_LOG > 0) ? SET_LOG : 1,
    localparam int ENTRY_W    = 1 + TAG_W + SET_W
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    scc_req_if.sink                 req,
    scc_cfg_if.sink                 cfg,
    output cfg_t                    cfg_q,
    output logic                    push,
    output logic [ENTRY_W-1:0]      push_data,
    input  wire logic               full
);

    cfg_t                     cfg_reg;
    cfg_t                     cfg_next;
    logic [TAG_W-1:0]         tag;
    logic [TAG_W+SET_W-1:0]   tag_ext;
    logic [SET_W-1:0]         set_idx;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_REPLACE_FIFO:   cfg_next.replace_fifo   = cfg.data[0];
                CFG_WRITE_BACK:     cfg_next.write_back     = cfg.data[0];
                CFG_WAYS_IN_USE:    cfg_next.ways_in_use    = cfg.data;
                CFG_SET_INDEX_BITS: cfg_next.set_index_bits = cfg.data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        tag     = req.byte_address[ADDR_BITS-1:OFF_BITS];
        tag_ext = {{SET_W{1'b0}}, tag};
        for (int i = 0; i < SET_W; i++)
        begin
            set_idx[i] = tag_ext[i] && (i < SET_LOG) &&
                         (5'(i) < {1'b0, cfg_reg.set_index_bits});
        end
    end

    assign req.ready = !full;
    assign push      = req.valid && !full;
    assign push_data = {req.func, tag, set_idx};

endmodule

`default_nettype wire

// File: design/scc_queue.sv
// Two-entry queue that decouples the front end from the lookup engine.
// Does not depend on scc_pkg.
`default_nettype none

module scc_queue #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    output logic              full,
    input  wire logic         pop,
    output logic              empty,
    output logic [W-1:0]      head
);

    logic [W-1:0] slot_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: design/scc_back.sv
// Lookup engine: reads a set's tag and status rows, resolves hit, fill and
// replacement, writes the rows back and keeps the counters. Depends on scc_pkg and scc_if.
`default_nettype none

module scc_back import scc_pkg::*; #(
    parameter int ADDR_BITS   = 48,
    parameter int BLOCK_BYTES = 64,
    parameter int MAX_SETS    = 256,
    parameter int MAX_WAYS    = 8,
    parameter int COUNT_BITS  = 32,
    localparam int OFF_BITS   = $clog2(BLOCK_BYTES),
    localparam int TAG_W      = ADDR_BITS - OFF_BITS,
    localparam int SET_LOG    = $clog2(MAX_SETS),
    localparam int SET_W      = (SET_LOG > 0) ? SET_LOG : 1,
    localparam int ENTRY_W    = 1 + TAG_W + SET_W
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  cfg_t                    cfg_q,
    input  wire logic               empty,
    input  wire logic [ENTRY_W-1:0] head,
    output logic                    pop,
    scc_rsp_if.source               rsp
);

    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W = WAY_W;
    localparam logic [RANK_W-1:0] MAX_RANK  = RANK_W'(MAX_WAYS - 1);
    localparam logic [5:0]        MAX_WAYS6 = 6'(MAX_WAYS);

    logic [MAX_WAYS-1:0][TAG_W-1:0]  tag_mem   [MAX_SETS];
    logic [MAX_WAYS-1:0]             valid_mem [MAX_SETS];
    logic [MAX_WAYS-1:0]             dirty_mem [MAX_SETS];
    logic [MAX_WAYS-1:0][RANK_W-1:0] rank_mem  [MAX_SETS];
    logic [MAX_SETS-1:0]             touched_reg;

    logic [MAX_WAYS-1:0][TAG_W-1:0]  tag_rd_reg;
    logic [MAX_WAYS-1:0]             valid_rd_reg;
    logic [MAX_WAYS-1:0]             dirty_rd_reg;
    logic [MAX_WAYS-1:0][RANK_W-1:0] rank_rd_reg;
    logic                            touched_rd_reg;

    back_state_t      state_reg;
    back_state_t      state_next;
    logic             is_write_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [SET_W-1:0] set_reg;
    logic [SET_W-1:0] head_set;

    logic [COUNT_BITS-1:0] hits_reg, hits_next;
    logic [COUNT_BITS-1:0] rmiss_reg, rmiss_next;
    logic [COUNT_BITS-1:0] wmiss_reg, wmiss_next;
    logic [COUNT_BITS-1:0] mrd_reg, mrd_next;
    logic [COUNT_BITS-1:0] mwr_reg, mwr_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_hit_reg;
    logic                   out_store_reg;
    logic                   out_evict_reg;
    logic [OUT_COUNT_W-1:0] out_hits_reg;
    logic [OUT_COUNT_W-1:0] out_rmiss_reg;
    logic [OUT_COUNT_W-1:0] out_wmiss_reg;
    logic [OUT_COUNT_W-1:0] out_mrd_reg;
    logic [OUT_COUNT_W-1:0] out_mwr_reg;

    logic                            commit;
    logic [5:0]                      ways_eff;
    logic [MAX_WAYS-1:0]             active;
    logic [MAX_WAYS-1:0]             valid_r;
    logic [MAX_WAYS-1:0]             dirty_r;
    logic [MAX_WAYS-1:0][RANK_W-1:0] rank_r;
    logic                            hit_any;
    logic [WAY_W-1:0]                hit_idx;
    logic                            free_any;
    logic [WAY_W-1:0]                free_idx;
    logic [WAY_W-1:0]                vict_idx;
    logic [WAY_W-1:0]                slot;
    logic                            store;
    logic                            evict;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  tag_new;
    logic [MAX_WAYS-1:0]             valid_new;
    logic [MAX_WAYS-1:0]             dirty_new;
    logic [MAX_WAYS-1:0][RANK_W-1:0] rank_new;

    assign head_set = head[SET_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        pop            = 1'b0;
        commit         = 1'b0;
        out_valid_next = out_valid_reg && !rsp.ready;
        case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    state_next = BK_UPDATE;
                end
            end
            BK_UPDATE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    commit         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cfg_q.ways_in_use == 4'd0)
        begin
            ways_eff = 6'd1;
        end
        else if ({2'b00, cfg_q.ways_in_use} > MAX_WAYS6)
        begin
            ways_eff = MAX_WAYS6;
        end
        else
        begin
            ways_eff = {2'b00, cfg_q.ways_in_use};
        end

        valid_r = touched_rd_reg ? valid_rd_reg : '0;
        dirty_r = touched_rd_reg ? dirty_rd_reg : '0;
        rank_r  = touched_rd_reg ? rank_rd_reg : '0;

        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        vict_idx = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            active[w] = (6'(w) < ways_eff);
            if (active[w] && valid_r[w] && !hit_any && tag_rd_reg[w] == tag_reg)
            begin
                hit_any = 1'b1;
                hit_idx = WAY_W'(w);
            end
            if (active[w] && !valid_r[w] && !free_any)
            begin
                free_any = 1'b1;
                free_idx = WAY_W'(w);
            end
            if (w > 0 && active[w] && rank_r[w] > rank_r[vict_idx])
            begin
                vict_idx = WAY_W'(w);
            end
        end
        slot = free_any ? free_idx : vict_idx;

        tag_new   = tag_rd_reg;
        valid_new = valid_r;
        dirty_new = dirty_r;
        rank_new  = rank_r;
        store     = 1'b0;
        evict     = 1'b0;
        if (hit_any)
        begin
            if (is_write_reg)
            begin
                if (cfg_q.write_back)
                begin
                    dirty_new[hit_idx] = 1'b1;
                end
                else
                begin
                    store = 1'b1;
                end
            end
            if (!cfg_q.replace_fifo)
            begin
                for (int w = 0; w < MAX_WAYS; w++)
                begin
                    if (active[w] && valid_r[w] && WAY_W'(w) != hit_idx &&
                        rank_r[w] < rank_r[hit_idx] && rank_r[w] != MAX_RANK)
                    begin
                        rank_new[w] = rank_r[w] + 1'b1;
                    end
                end
                rank_new[hit_idx] = '0;
            end
        end
        else
        begin
            store = is_write_reg && !cfg_q.write_back;
            if (!free_any)
            begin
                evict = 1'b1;
                if (cfg_q.write_back && dirty_r[slot])
                begin
                    store = 1'b1;
                end
            end
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                if (active[w] && valid_r[w] && WAY_W'(w) != slot &&
                    rank_r[w] != MAX_RANK)
                begin
                    rank_new[w] = rank_r[w] + 1'b1;
                end
            end
            valid_new[slot] = 1'b1;
            tag_new[slot]   = tag_reg;
            dirty_new[slot] = is_write_reg && cfg_q.write_back;
            rank_new[slot]  = '0;
        end

        hits_next  = (hit_any && hits_reg != '1) ? hits_reg + 1'b1 : hits_reg;
        rmiss_next = (!hit_any && !is_write_reg && rmiss_reg != '1) ?
                     rmiss_reg + 1'b1 : rmiss_reg;
        wmiss_next = (!hit_any && is_write_reg && wmiss_reg != '1) ?
                     wmiss_reg + 1'b1 : wmiss_reg;
        mrd_next   = (!hit_any && mrd_reg != '1) ? mrd_reg + 1'b1 : mrd_reg;
        mwr_next   = (store && mwr_reg != '1) ? mwr_reg + 1'b1 : mwr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            touched_reg   <= '0;
            hits_reg      <= '0;
            rmiss_reg     <= '0;
            wmiss_reg     <= '0;
            mrd_reg       <= '0;
            mwr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                touched_reg[set_reg] <= 1'b1;
                hits_reg             <= hits_next;
                rmiss_reg            <= rmiss_next;
                wmiss_reg            <= wmiss_next;
                mrd_reg              <= mrd_next;
                mwr_reg              <= mwr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            is_write_reg   <= head[ENTRY_W-1];
            tag_reg        <= head[ENTRY_W-2:SET_W];
            set_reg        <= head_set;
            tag_rd_reg     <= tag_mem[head_set];
            valid_rd_reg   <= valid_mem[head_set];
            dirty_rd_reg   <= dirty_mem[head_set];
            rank_rd_reg    <= rank_mem[head_set];
            touched_rd_reg <= touched_reg[head_set];
        end
        if (commit)
        begin
            tag_mem[set_reg]   <= tag_new;
            valid_mem[set_reg] <= valid_new;
            dirty_mem[set_reg] <= dirty_new;
            rank_mem[set_reg]  <= rank_new;
            out_hit_reg        <= hit_any;
            out_store_reg      <= store;
            out_evict_reg      <= evict;
            out_hits_reg       <= OUT_COUNT_W'(hits_next);
            out_rmiss_reg      <= OUT_COUNT_W'(rmiss_next);
            out_wmiss_reg      <= OUT_COUNT_W'(wmiss_next);
            out_mrd_reg        <= OUT_COUNT_W'(mrd_next);
            out_mwr_reg        <= OUT_COUNT_W'(mwr_next);
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.hit                = out_hit_reg;
    assign rsp.mem_fetch          = !out_hit_reg;
    assign rsp.mem_store          = out_store_reg;
    assign rsp.evicted            = out_evict_reg;
    assign rsp.total_hits         = out_hits_reg;
    assign rsp.total_read_misses  = out_rmiss_reg;
    assign rsp.total_write_misses = out_wmiss_reg;
    assign rsp.total_mem_reads    = out_mrd_reg;
    assign rsp.total_mem_writes   = out_mwr_reg;

endmodule

`default_nettype wire

// File: design/set_assoc_cache_controller_core.sv
// Top level of the set-associative cache controller: front end, queue, lookup engine.
// Depends on scc_pkg, scc_if, scc_front, scc_queue and scc_back.
//
//   Channel | Direction | Carries
//   req     | in        | func, byte_address
//   rsp     | out       | hit, mem_fetch, mem_store, evicted, five counters
//   cfg     | in        | index, data (register writes, always ready)
//
// In the lookup engine, BK_IDLE pops an access and registers its set's rows, and
// BK_UPDATE resolves the access and writes the rows back. With the engine idle
// and the queue empty, a request is written into the queue, popped with its set's
// rows registered, then resolved into the output registers that offer the result;
// each access ahead of it in the queue or the engine goes through these steps
// first. After reset every set reads as empty at once, with no clearing pass.
// A stalled response holds the engine while the queue takes up to two requests.
`default_nettype none

module set_assoc_cache_controller_core import scc_pkg::*; #(
    parameter int ADDR_BITS   = 48,
    parameter int BLOCK_BYTES = 64,
    parameter int MAX_SETS    = 256,
    parameter int MAX_WAYS    = 8,
    parameter int COUNT_BITS  = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    scc_req_if.sink   req,
    scc_rsp_if.source rsp,
    scc_cfg_if.sink   cfg
);

    localparam int OFF_BITS = $clog2(BLOCK_BYTES);
    localparam int TAG_W    = ADDR_BITS - OFF_BITS;
    localparam int SET_LOG  = $clog2(MAX_SETS);
    localparam int SET_W    = (SET_LOG > 0) ? SET_LOG : 1;
    localparam int ENTRY_W  = 1 + TAG_W + SET_W;

    cfg_t               cfg_q;
    logic               push;
    logic [ENTRY_W-1:0] push_data;
    logic               full;
    logic               pop;
    logic               empty;
    logic [ENTRY_W-1:0] head;

    scc_front #(
        .ADDR_BITS   (ADDR_BITS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .MAX_SETS    (MAX_SETS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg       (cfg),
        .cfg_q     (cfg_q),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    scc_queue #(
        .W (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    scc_back #(
        .ADDR_BITS   (ADDR_BITS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .MAX_SETS    (MAX_SETS),
        .MAX_WAYS    (MAX_WAYS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg_q (cfg_q),
        .empty (empty),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// File: dv/set_assoc_cache_controller_core_tb.sv
// Self-checking testbench for the set-associative cache controller core.
// Drives accesses and register writes, predicts hit, memory traffic and counters.
// Depends on scc_pkg, scc_if and set_assoc_cache_controller_core from the design folder.
`timescale 1ns / 100ps

module set_assoc_cache_controller_core_tb;
    import scc_pkg::*;

    typedef struct packed {
        logic        hit;
        logic        mem_fetch;
        logic        mem_store;
        logic        evicted;
        logic [31:0] hits;
        logic [31:0] read_misses;
        logic [31:0] write_misses;
        logic [31:0] mem_reads;
        logic [31:0] mem_writes;
    } access_result_t;

    class cache_scoreboard;
        logic [41:0]    tags[2048];
        bit             valid[2048];
        bit             dirty[2048];
        bit [2:0]       age[2048];
        bit [31:0]      n_hits, n_rmiss, n_wmiss, n_mrd, n_mwr;
        cfg_t           cfg;
        access_result_t pending[$];
        int             errors;
        int             checked;
        int             n_evicts;

        function new();
            foreach (valid[i])
            begin
                valid[i] = 0;
                dirty[i] = 0;
                age[i] = 0;
                tags[i] = '0;
            end
            cfg = CFG_RESET;
        endfunction

        function void write_reg(logic [3:0] idx, logic [3:0] val);
            case (idx)
                CFG_REPLACE_FIFO:   cfg.replace_fifo = val[0];
                CFG_WRITE_BACK:     cfg.write_back = val[0];
                CFG_WAYS_IN_USE:    cfg.ways_in_use = val;
                CFG_SET_INDEX_BITS: cfg.set_index_bits = val;
                default: ;
            endcase
        endfunction

        function void bump(ref bit [31:0] c);
            if (c != 32'hFFFF_FFFF)
                c++;
        endfunction

        function void note_access(logic fn, logic [47:0] addr);
            logic [41:0]    blk;
            int             nsets, ways, base, found, freeway, slot, k;
            bit             hit, have_free, ev, st, wr;
            access_result_t r;
            wr = (fn == FUNC_WRITE);
            blk = addr[47:6];
            nsets = 1 << ((cfg.set_index_bits > 8) ? 8 : cfg.set_index_bits);
            ways = int'(cfg.ways_in_use);
            if (ways == 0)
                ways = 1;
            if (ways > 8)
                ways = 8;
            base = int'(blk[7:0] & 8'(nsets - 1)) * 8;
            hit = 0;
            have_free = 0;
            ev = 0;
            st = 0;
            found = 0;
            freeway = 0;
            for (int w = 0; w < ways; w++)
            begin
                k = base + w;
                if (valid[k])
                begin
                    if (!hit && tags[k] == blk)
                    begin
                        hit = 1;
                        found = k;
                    end
                end
                else if (!have_free)
                begin
                    have_free = 1;
                    freeway = k;
                end
            end
            if (hit)
            begin
                bump(n_hits);
                if (wr)
                begin
                    if (cfg.write_back)
                        dirty[found] = 1;
                    else
                        st = 1;
                end
                if (!cfg.replace_fifo)
                begin
                    for (int w = 0; w < ways; w++)
                    begin
                        k = base + w;
                        if (k != found && valid[k] && age[k] < age[found] && age[k] < 7)
                            age[k]++;
                    end
                    age[found] = 0;
                end
            end
            else
            begin
                if (wr)
                    bump(n_wmiss);
                else
                    bump(n_rmiss);
                bump(n_mrd);
                if (wr && !cfg.write_back)
                    st = 1;
                if (have_free)
                    slot = freeway;
                else
                begin
                    slot = base;
                    for (int w = 1; w < ways; w++)
                        if (age[base + w] > age[slot])
                            slot = base + w;
                    ev = 1;
                    n_evicts++;
                    if (cfg.write_back && dirty[slot])
                        st = 1;
                end
                for (int w = 0; w < ways; w++)
                begin
                    k = base + w;
                    if (k != slot && valid[k] && age[k] < 7)
                        age[k]++;
                end
                valid[slot] = 1;
                tags[slot] = blk;
                dirty[slot] = wr && cfg.write_back;
                age[slot] = 0;
            end
            if (st)
                bump(n_mwr);
            r = '{hit, !hit, st, ev, n_hits, n_rmiss, n_wmiss, n_mrd, n_mwr};
            pending.push_back(r);
        endfunction

        function void check_result(access_result_t got);
            access_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.hit !== want.hit)
                $display("%0t: hit expected %b actual %b", $time, want.hit, got.hit);
            if (got.mem_fetch !== want.mem_fetch)
                $display("%0t: mem_fetch expected %b actual %b", $time,
                         want.mem_fetch, got.mem_fetch);
            if (got.mem_store !== want.mem_store)
                $display("%0t: mem_store expected %b actual %b", $time,
                         want.mem_store, got.mem_store);
            if (got.evicted !== want.evicted)
                $display("%0t: evicted expected %b actual %b", $time, want.evicted, got.evicted);
            if (got.hits !== want.hits)
                $display("%0t: total_hits expected %0d actual %0d", $time, want.hits, got.hits);
            if (got.read_misses !== want.read_misses)
                $display("%0t: total_read_misses expected %0d actual %0d", $time,
                         want.read_misses, got.read_misses);
            if (got.write_misses !== want.write_misses)
                $display("%0t: total_write_misses expected %0d actual %0d", $time,
                         want.write_misses, got.write_misses);
            if (got.mem_reads !== want.mem_reads)
                $display("%0t: total_mem_reads expected %0d actual %0d", $time,
                         want.mem_reads, got.mem_reads);
            if (got.mem_writes !== want.mem_writes)
                $display("%0t: total_mem_writes expected %0d actual %0d", $time,
                         want.mem_writes, got.mem_writes);
            if (got !== want)
                errors++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_off;
    int   items_sent;

    scc_req_if #(.ADDR_BITS(48)) req ();
    scc_rsp_if rsp ();
    scc_cfg_if cfg ();

    cache_scoreboard sb;

    set_assoc_cache_controller_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("set_assoc_cache_controller_core_tb NOT OK");
        $finish;
    end

    // Response side: random stalls, plus a long hold-off when requested.
    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready)
            sb.check_result('{rsp.hit, rsp.mem_fetch, rsp.mem_store, rsp.evicted,
                              rsp.total_hits, rsp.total_read_misses,
                              rsp.total_write_misses, rsp.total_mem_reads,
                              rsp.total_mem_writes});
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_access(logic fn, logic [47:0] addr);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.func <= fn;
        req.byte_address <= addr;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sb.note_access(fn, addr);
        items_sent++;
    endtask

    task automatic drain();
        int guard;
        req.valid <= 1'b0;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        if (sb.pending.size() != 0)
        begin
            $display("set_assoc_cache_controller_core_tb NOT OK");
            $finish;
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [3:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic set_config(bit fifo, bit wb, logic [3:0] ways, logic [3:0] sbits);
        drain();
        write_reg(CFG_REPLACE_FIFO, {3'b0, fifo});
        write_reg(CFG_WRITE_BACK, {3'b0, wb});
        write_reg(CFG_WAYS_IN_USE, ways);
        write_reg(CFG_SET_INDEX_BITS, sbits);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly a small pool of blocks mapped onto few sets, so hits and evictions occur.
    function automatic logic [47:0] pick_address(int sbits);
        logic [47:0] a;
        a = 48'({$urandom, $urandom});
        if ($urandom_range(9) < 8)
        begin
            a[47:6] = {2'($urandom_range(3)), 40'b0} ^ {37'b0, 5'($urandom_range(23))};
            if (sbits > 2)
                a[13:6] = {2'($urandom_range(3)), 6'b0} | {6'b0, a[7:6]};
        end
        return a;
    endfunction

    task automatic run_phase(int n, int sbits);
        for (int i = 0; i < n; i++)
            send_access(1'($urandom_range(1)), pick_address(sbits));
    endtask

    initial
    begin
        int phase_cfgs[10][4];
        sb = new();
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.func = FUNC_READ;
        req.byte_address = '0;
        rsp.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = CFG_REPLACE_FIFO;
        cfg.data = '0;
        send_idle_pct = 13;
        recv_idle_pct = 74;
        hold_off = 0;
        items_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme addresses, both functions, fills and hits at reset config.
        send_access(FUNC_READ, 48'h0);
        send_access(FUNC_WRITE, 48'hFFFF_FFFF_FFFF);
        send_access(FUNC_READ, 48'hFFFF_FFFF_FFC0);
        send_access(FUNC_WRITE, 48'h0000_0000_003F);
        for (int i = 0; i < 9; i++)
            send_access(i[0], {6'h2A, i[35:0], 6'h15} & 48'hFFFF_FFFF_C03F);
        send_access(FUNC_READ, 48'h0);
        send_access(FUNC_WRITE, 48'h0);
        // Out-of-range geometry: zero ways, too many ways and sets, write-through eviction.
        set_config(1'b1, 1'b0, 4'd0, 4'd15);
        send_access(FUNC_WRITE, 48'h40);
        send_access(FUNC_READ, 48'h4040);
        send_access(FUNC_READ, 48'h40);
        set_config(1'b0, 1'b0, 4'd15, 4'd0);
        for (int i = 0; i < 10; i++)
            send_access(FUNC_WRITE, 48'({$urandom, $urandom}));

        phase_cfgs = '{'{0, 1, 8, 0}, '{1, 1, 2, 1}, '{0, 0, 4, 2}, '{1, 0, 1, 3},
                       '{0, 1, 3, 8}, '{1, 1, 8, 2}, '{0, 1, 5, 1}, '{1, 0, 7, 0},
                       '{0, 1, 2, 4}, '{0, 1, 8, 8}};
        for (int p = 0; p < 10; p++)
        begin
            if (p == 4)
            begin
                send_idle_pct = 74;
                recv_idle_pct = 13;
            end
            if (p == 7)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_config(1'(phase_cfgs[p][0]), 1'(phase_cfgs[p][1]), 4'(phase_cfgs[p][2]),
                       4'(phase_cfgs[p][3]));
            if (p == 8)
            begin
                @(posedge clk);
                hold_off <= 300;
            end
            run_phase(170, phase_cfgs[p][3]);
        end

        drain();
        $display("Covered %0d accesses, %0d results checked, %0d evictions,",
                 items_sent, sb.checked, sb.n_evicts);
        $display("over ten cache geometries with stalls on both sides.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("set_assoc_cache_controller_core_tb OK");
        else
            $display("set_assoc_cache_controller_core_tb NOT OK");
        $finish;
    end
endmodule

// File: files.f
design/scc_pkg.sv
design/scc_if.sv
design/scc_front.sv
design/scc_queue.sv
design/scc_back.sv
design/set_assoc_cache_controller_core.sv
dv/set_assoc_cache_controller_core_tb.sv
